// ===== sv/see_pkg.sv =====
// Shared types, character constants and character-generation functions for
// the string escape encoder. No dependencies.
`default_nettype none
package see_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CP_W  = 21;
  localparam int IDX_W = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_QUOTE_QUOTES = 2'd0;
  localparam logic [1:0] REG_ESCAPE_HIGH  = 2'd1;
  localparam logic [1:0] REG_EOL_MODE     = 2'd2;

  // Commands.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_EOS    = 1'b1;

  // Line end modes.
  localparam logic [1:0] EOL_NONE = 2'd0;
  localparam logic [1:0] EOL_LF   = 2'd1;
  localparam logic [1:0] EOL_CRLF = 2'd2;
  localparam logic [1:0] EOL_CR   = 2'd3;

  // Input code points with special treatment.
  localparam logic [CP_W-1:0] CP_BS     = 21'h08;
  localparam logic [CP_W-1:0] CP_TAB    = 21'h09;
  localparam logic [CP_W-1:0] CP_LF     = 21'h0A;
  localparam logic [CP_W-1:0] CP_FF     = 21'h0C;
  localparam logic [CP_W-1:0] CP_CR     = 21'h0D;
  localparam logic [CP_W-1:0] CP_SPACE  = 21'h20;
  localparam logic [CP_W-1:0] CP_DEL    = 21'h7F;
  localparam logic [CP_W-1:0] CP_HIGH   = 21'h80;
  localparam logic [CP_W-1:0] CP_PLANE1 = 21'h10000;
  localparam logic [CP_W-1:0] CP_DQUOTE = 21'h22;
  localparam logic [CP_W-1:0] CP_SQUOTE = 21'h27;
  localparam logic [CP_W-1:0] CP_BSLASH = 21'h5C;

  // Emitted characters.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U_LO   = 8'h75;
  localparam logic [7:0] CH_U_HI   = 8'h55;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;

  typedef enum logic [2:0] {
    K_PLAIN,     // code point as is
    K_ESC,       // backslash and the character held in cp
    K_HEX2,      // \xHH
    K_HEX4,      // \uHHHH
    K_HEX8,      // \UHHHHHHHH
    K_CRFLUSH,   // \r and line end
    K_NEWLINE    // optional \r, then \n and line end
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             held;
    logic [1:0]       eol;
    logic [CP_W-1:0]  cp;
  } desc_t;

  function automatic logic [1:0] eol_len(logic [1:0] mode);
    logic [1:0] n;
    case (mode)
      EOL_LF:   n = 2'd1;
      EOL_CRLF: n = 2'd2;
      EOL_CR:   n = 2'd1;
      default:  n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] eol_char(logic [1:0] mode, logic j);
    logic [7:0] c;
    case (mode)
      EOL_CRLF: c = j ? CH_LF : CH_CR;
      EOL_CR:   c = CH_CR;
      default:  c = CH_LF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = CH_ZERO + {4'd0, nib};
    else             c = CH_A + {4'd0, nib} - 8'd10;
    return c;
  endfunction

  // Number of characters a descriptor expands to.
  function automatic logic [IDX_W-1:0] desc_len(desc_t d);
    logic [IDX_W-1:0] n;
    unique case (d.kind)
      K_PLAIN:   n = 4'd1;
      K_ESC:     n = 4'd2;
      K_HEX2:    n = 4'd4;
      K_HEX4:    n = 4'd6;
      K_HEX8:    n = 4'd10;
      K_CRFLUSH: n = 4'd2 + {2'd0, eol_len(d.eol)};
      K_NEWLINE: n = 4'd2 + (d.held ? 4'd2 : 4'd0) + {2'd0, eol_len(d.eol)};
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

  // Character number idx of a descriptor's expansion.
  function automatic logic [CP_W-1:0] desc_char(desc_t d, logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic [2:0]       last_pos;
    logic [2:0]       pos;
    logic [31:0]      wide;
    logic [3:0]       nib;
    logic [7:0]       c;
    logic [CP_W-1:0]  r;
    j        = idx - 4'd2;
    wide     = {11'd0, d.cp};
    last_pos = 3'd1;
    c        = CH_BSLASH;
    r        = '0;
    unique case (d.kind)
      K_HEX4:  last_pos = 3'd3;
      K_HEX8:  last_pos = 3'd7;
      default: last_pos = 3'd1;
    endcase
    pos = last_pos - j[2:0];
    nib = wide[{pos, 2'b00} +: 4];
    unique case (d.kind)
      K_PLAIN: r = d.cp;
      K_ESC:   r = (idx == 4'd0) ? {13'd0, CH_BSLASH} : d.cp;
      K_HEX2, K_HEX4, K_HEX8: begin
        if (idx == 4'd0) c = CH_BSLASH;
        else if (idx == 4'd1) begin
          c = (d.kind == K_HEX2) ? CH_X : ((d.kind == K_HEX4) ? CH_U_LO : CH_U_HI);
        end else c = hex_char(nib);
        r = {13'd0, c};
      end
      K_CRFLUSH: begin
        if (idx == 4'd0) c = CH_BSLASH;
        else if (idx == 4'd1) c = CH_R;
        else c = eol_char(d.eol, j[0]);
        r = {13'd0, c};
      end
      K_NEWLINE: begin
        k = d.held ? j : idx;
        if (d.held && idx == 4'd0) c = CH_BSLASH;
        else if (d.held && idx == 4'd1) c = CH_R;
        else if (k == 4'd0) c = CH_BSLASH;
        else if (k == 4'd1) c = CH_N;
        else c = eol_char(d.eol, k[0]);
        r = {13'd0, c};
      end
      default: r = d.cp;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/see_front.sv =====
// Front end: accepts input items, tracks the held carriage return and turns
// each item into an expansion descriptor. Depends on see_pkg.
`default_nettype none
module see_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       push,
  input  wire                       command,
  input  wire [see_pkg::CP_W-1:0]   code_point,
  input  wire                       quote_quotes,
  input  wire                       escape_high_unicode,
  input  wire [1:0]                 eol_mode,
  input  wire                       q_full,
  output logic                      q_push,
  output see_pkg::desc_t            q_wdata,
  output logic                      pending_cr
);

  logic accept;
  logic emits;
  logic pending_cr_next;

  assign accept = push && !q_full;

  always_comb begin
    emits           = 1'b1;
    pending_cr_next = 1'b0;
    q_wdata.kind    = see_pkg::K_PLAIN;
    q_wdata.held    = pending_cr;
    q_wdata.eol     = eol_mode;
    q_wdata.cp      = code_point;
    if (command == see_pkg::CMD_EOS) begin
      q_wdata.kind = see_pkg::K_CRFLUSH;
      emits        = pending_cr;
    end else if (code_point < see_pkg::CP_SPACE || code_point == see_pkg::CP_DEL) begin
      unique case (code_point)
        see_pkg::CP_TAB: begin
          q_wdata.kind = see_pkg::K_ESC;
          q_wdata.cp   = {13'd0, see_pkg::CH_T};
        end
        see_pkg::CP_BS: begin
          q_wdata.kind = see_pkg::K_ESC;
          q_wdata.cp   = {13'd0, see_pkg::CH_B};
        end
        see_pkg::CP_FF: begin
          q_wdata.kind = see_pkg::K_ESC;
          q_wdata.cp   = {13'd0, see_pkg::CH_F};
        end
        see_pkg::CP_LF: q_wdata.kind = see_pkg::K_NEWLINE;
        see_pkg::CP_CR: begin
          q_wdata.kind    = see_pkg::K_CRFLUSH;
          emits           = pending_cr;
          pending_cr_next = 1'b1;
        end
        default: q_wdata.kind = see_pkg::K_HEX2;
      endcase
    end else if (code_point < see_pkg::CP_HIGH || !escape_high_unicode) begin
      if ((quote_quotes && code_point == see_pkg::CP_DQUOTE) ||
          (!quote_quotes && code_point == see_pkg::CP_SQUOTE) ||
          code_point == see_pkg::CP_BSLASH) begin
        q_wdata.kind = see_pkg::K_ESC;
      end
    end else if (code_point < see_pkg::CP_PLANE1) begin
      q_wdata.kind = see_pkg::K_HEX4;
    end else begin
      q_wdata.kind = see_pkg::K_HEX8;
    end
  end

  assign q_push = accept && emits;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cr <= 1'b0;
    end else if (accept) begin
      pending_cr <= pending_cr_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/see_queue.sv =====
// Short descriptor queue between the front end and the expansion sequencer.
// Depends on see_pkg.
`default_nettype none
module see_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr,
  input  see_pkg::desc_t       wdata,
  input  wire                  rd,
  output see_pkg::desc_t       rdata,
  output logic                 q_full,
  output logic                 q_empty
);

  see_pkg::desc_t                  mem [see_pkg::QDEPTH];
  logic [see_pkg::QPTR_W-1:0]      wptr;
  logic [see_pkg::QPTR_W-1:0]      rptr;
  logic [see_pkg::QCNT_W-1:0]      count;

  assign q_full  = (count == see_pkg::QCNT_W'(see_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      if (wr && !rd)      count <= count + 1'b1;
      else if (!wr && rd) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/see_back.sv =====
// Back end: steps through the head descriptor one character per cycle unless
// stalled; holds each character in the output register. Depends on see_pkg.
`default_nettype none
module see_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       q_empty,
  input  see_pkg::desc_t            q_rdata,
  output logic                      q_pop,
  input  wire                       pop,
  output logic                      out_valid,
  output logic [see_pkg::CP_W-1:0]  out_char,
  output logic                      last
);

  logic [see_pkg::IDX_W-1:0] idx;
  logic                      advance;
  logic                      is_last;

  assign advance = !q_empty && (!out_valid || pop);
  assign is_last = (idx == see_pkg::desc_len(q_rdata) - 4'd1);
  assign q_pop   = advance && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      idx       <= is_last ? '0 : idx + 4'd1;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= see_pkg::desc_char(q_rdata, idx);
      last     <= is_last;
    end
  end

endmodule
`default_nettype wire

// ===== sv/string_escape_encoder_top.sv =====
// Top level of the string escape encoder: configuration registers, front end,
// descriptor queue and expansion sequencer. Depends on see_pkg, see_front,
// see_queue and see_back.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         push / full                 command, code_point
//   result    out        empty / pop                 out_char, last
//   config    in         psel, penable, pwrite, ...  paddr, pwdata, prdata
//
// An input item is classified in the cycle it is accepted and placed in a
// four-entry descriptor queue; items that produce nothing (a first carriage
// return, end of stream with no carriage return held) only update the held
// flag. The sequencer emits one character per cycle while the consumer does
// not stall; an item expands to 1 character for plain text, up to 10 for the
// \U form. The first character of an item passes through the queue and the
// output register before it reaches the result ports. Input is accepted while
// the queue has room; the output register is refilled in the same cycle its
// character makes its transfer, and while the consumer stalls the sequencer
// holds. Reset is synchronous: it empties the queue and output register, drops
// any held carriage return and restores the registers to their reset values.
`default_nettype none
module string_escape_encoder_top (
  input  wire                       clk,
  input  wire                       rst,
  // Input queue side.
  input  wire                       push,
  output logic                      full,
  input  wire                       command,
  input  wire [see_pkg::CP_W-1:0]   code_point,
  // Result queue side.
  output logic                      empty,
  input  wire                       pop,
  output logic [see_pkg::CP_W-1:0]  out_char,
  output logic                      last,
  // Configuration port.
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [3:0]                 paddr,
  input  wire [31:0]                pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Configuration registers, one per 32-bit word.
  logic       quote_quotes;
  logic       escape_high_unicode;
  logic [1:0] eol_mode;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_quotes        <= 1'b1;
      escape_high_unicode <= 1'b1;
      eol_mode            <= see_pkg::EOL_NONE;
    end else if (cfg_write) begin
      // Writes to addresses past the last register are ignored.
      case (paddr[3:2])
        see_pkg::REG_QUOTE_QUOTES: quote_quotes        <= pwdata[0];
        see_pkg::REG_ESCAPE_HIGH:  escape_high_unicode <= pwdata[0];
        see_pkg::REG_EOL_MODE:     eol_mode            <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      see_pkg::REG_QUOTE_QUOTES: prdata = {31'd0, quote_quotes};
      see_pkg::REG_ESCAPE_HIGH:  prdata = {31'd0, escape_high_unicode};
      see_pkg::REG_EOL_MODE:     prdata = {30'd0, eol_mode};
      default:                   prdata = '0;
    endcase
  end

  // Front end to queue.
  logic           q_push;
  see_pkg::desc_t q_wdata;
  logic           pending_cr;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  see_pkg::desc_t q_rdata;
  logic           out_valid;

  // The input side is full exactly when the descriptor queue is, even for
  // items that would not produce a descriptor.
  assign full  = q_full;
  assign empty = !out_valid;

  see_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .command             (command),
    .code_point          (code_point),
    .quote_quotes        (quote_quotes),
    .escape_high_unicode (escape_high_unicode),
    .eol_mode            (eol_mode),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_wdata             (q_wdata),
    .pending_cr          (pending_cr)
  );

  see_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   (q_wdata),
    .rd      (q_pop),
    .rdata   (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  see_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_char  (out_char),
    .last      (last)
  );

  // A waiting descriptor with a free output register must produce a result
  // transfer candidate in the next cycle.
  a_back_progress: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && empty) |=> !empty)
    else $error("sequencer stalled with work queued and output free");

  // A carriage return is only held after one was accepted.
  a_cr_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pending_cr) |->
      $past(push && !full && command == see_pkg::CMD_ENCODE &&
            code_point == see_pkg::CP_CR))
    else $error("held carriage return set without a carriage return input");

  // The input side never reports full while the queue holds nothing.
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_empty)
    else $error("full reported with an empty queue");

endmodule
`default_nettype wire
